// File: rtl/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Field widths, status and op codes, controller states and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package lpht_pkg;

	// Default table size (slots)
	localparam int TABLE_SIZE_DEF = 16;

	// Field widths
	localparam int KEY_W    = 31;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int PROBES_W = 5;
	localparam int OCC_W    = 5;

	// Op codes
	typedef logic op_t;
	localparam op_t OP_INSERT = 1'b0;
	localparam op_t OP_SEARCH = 1'b1;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t STAT_OK   = 2'd0;
	localparam status_t STAT_MISS = 2'd1;
	localparam status_t STAT_FULL = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_wr;   // write an empty word at the clear pointer
		logic capture;    // latch op and key of an accepted request
		logic hash_run;   // run the home slot reduction
		logic load_home;  // read the home slot, start the walk
		logic advance;    // step to the next slot
		logic finish;     // load the result register, commit an insert
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last; // clear pointer sits on the last slot
		logic hash_done;  // home slot is ready
		logic probe_end;  // the slot now read ends the walk
	} dp_stat_t;

endpackage

// File: rtl/lpht_ram.sv
// ---------------------------------------------------------------------------
// lpht_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/lpht_ctrl.sv
// ---------------------------------------------------------------------------
// lpht_ctrl: sequencer of the linear probe hash table
// Clears the store after reset, accepts one request at a time, runs the home
// slot reduction and the probe walk, and owns the result valid flag.
// ---------------------------------------------------------------------------
module lpht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lpht_pkg::dp_stat_t st,
	output lpht_pkg::cmd_t     cmd
);

	import lpht_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	// Result register can take a new result
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_nx = S_HASH;
				end
			end
			S_HASH: begin
				if (st.hash_done) begin
					state_nx = S_PROBE;
				end
			end
			S_PROBE: begin
				if (st.probe_end && out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_HASH: begin
				cmd.hash_run  = 1'b1;
				cmd.load_home = st.hash_done;
			end
			S_PROBE: begin
				cmd.advance = !st.probe_end;
				cmd.finish  = st.probe_end && out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A result only comes out of the probe walk
	a_result_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PROBE))
		else $error("result appeared outside the probe walk");

	// A held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.finish)
		else $error("result register overwritten while held");

	// Store writes only during clearing or at the end of a walk
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_wr || cmd.finish) |-> (state_q == S_CLEAR || state_q == S_PROBE))
		else $error("store write outside clear or probe");

endmodule

// File: rtl/lpht_dp.sv
// ---------------------------------------------------------------------------
// lpht_dp: datapath of the linear probe hash table
// Request registers, home slot reduction, probe pointer and counter, key
// store with per-slot valid bit, entry count and result register.
// ---------------------------------------------------------------------------
module lpht_dp #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lpht_pkg::cmd_t                   cmd,
	output lpht_pkg::dp_stat_t               st,
	input  lpht_pkg::op_t                    in_op,
	input  logic [lpht_pkg::KEY_W-1:0]       in_key,
	output lpht_pkg::status_t                status,
	output logic [lpht_pkg::SLOT_W-1:0]      slot,
	output logic [lpht_pkg::PROBES_W-1:0]    probes,
	output logic [lpht_pkg::OCC_W-1:0]       occupancy
);

	import lpht_pkg::*;

	localparam int IDXW    = $clog2(TABLE_SIZE);
	localparam int CNTW    = $clog2(TABLE_SIZE + 1);
	localparam int WORDW   = KEY_W + 1;
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	// Request
	op_t              op_q;
	logic [KEY_W-1:0] key_q;

	// Walk state
	logic [IDXW-1:0] home;
	logic [IDXW-1:0] ptr_q;
	logic [IDXW-1:0] ptr_nx;
	logic [CNTW-1:0] n_q;
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] occ_nx;
	logic [IDXW-1:0] clr_q;

	// Store port
	logic             we;
	logic [IDXW-1:0]  waddr;
	logic [WORDW-1:0] wdata;
	logic [IDXW-1:0]  raddr;
	logic [WORDW-1:0] rdata;
	logic             rd_valid;
	logic [KEY_W-1:0] rd_key;

	// Result decode
	logic            hit;
	logic            store;
	status_t         res_status;
	logic [IDXW-1:0] res_slot;
	logic [15:0]     slot_w;
	logic [15:0]     probes_w;
	logic [15:0]     occ_w;
	logic            hash_done;

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
	end

	// Home slot: key modulo table size
	generate
		if (IS_POW2) begin : g_hash_mask
			assign home      = key_q[IDXW-1:0];
			assign hash_done = 1'b1;
		end else begin : g_hash_recip
			// Reciprocal multiply, product registered first and then the remainder: the
			// quotient comes from the top product bits, the remainder is key minus quotient times size
			localparam int              QSH   = KEY_W + IDXW;
			localparam int              PRODW = KEY_W + 32;
			localparam longint unsigned RECIP =
				((64'd1 << QSH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);

			logic [31:0]      recip_c;
			logic [PRODW-1:0] prod_q;
			logic [KEY_W-1:0] quo;
			logic [KEY_W-1:0] rem;
			logic [IDXW-1:0]  rem_q;
			logic             hstep_q;
			logic             hdone_q;

			assign recip_c = 32'(RECIP);
			assign quo     = KEY_W'(prod_q >> QSH);
			assign rem     = key_q - quo * KEY_W'(TABLE_SIZE);

			always_ff @(posedge clk) begin
				if (cmd.hash_run && !hdone_q) begin
					if (!hstep_q) begin
						prod_q <= PRODW'(key_q) * PRODW'(recip_c);
					end else begin
						rem_q <= rem[IDXW-1:0];
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hstep_q <= 1'b0;
					hdone_q <= 1'b0;
				end else if (cmd.capture) begin
					hstep_q <= 1'b0;
					hdone_q <= 1'b0;
				end else if (cmd.hash_run && !hdone_q) begin
					if (!hstep_q) begin
						hstep_q <= 1'b1;
					end else begin
						hdone_q <= 1'b1;
					end
				end
			end

			assign home      = rem_q;
			assign hash_done = hdone_q;
		end
	endgenerate

	// Next slot with wraparound
	assign ptr_nx = (ptr_q == IDXW'(TABLE_SIZE - 1)) ? '0 : ptr_q + IDXW'(1);

	// Probe pointer and probe count
	always_ff @(posedge clk) begin
		if (cmd.load_home) begin
			ptr_q <= home;
		end else if (cmd.advance) begin
			ptr_q <= ptr_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.load_home) begin
			n_q <= CNTW'(1);
		end else if (cmd.advance) begin
			n_q <= n_q + CNTW'(1);
		end
	end

	// Clearing pass pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + IDXW'(1);
		end
	end

	// Store: one write port, read address follows the walk; a stalled walk
	// re-reads its current slot
	assign we    = cmd.clear_wr || (cmd.finish && store);
	assign waddr = cmd.clear_wr ? clr_q : ptr_q;
	assign wdata = cmd.clear_wr ? '0 : {1'b1, key_q};
	assign raddr = cmd.load_home ? home : (cmd.advance ? ptr_nx : ptr_q);

	lpht_ram #(
		.WIDTH (WORDW),
		.DEPTH (TABLE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_valid = rdata[KEY_W];
	assign rd_key   = rdata[KEY_W-1:0];

	// Decide on the slot just read
	assign hit = (op_q == OP_SEARCH) && rd_valid && (rd_key == key_q);

	always_comb begin
		res_status = STAT_OK;
		res_slot   = '0;
		store      = 1'b0;
		if (!rd_valid) begin
			if (op_q == OP_INSERT) begin
				store    = 1'b1;
				res_slot = ptr_q;
			end else begin
				res_status = STAT_MISS;
			end
		end else if (hit) begin
			res_slot = ptr_q;
		end else if (op_q == OP_INSERT) begin
			res_status = STAT_FULL;
		end else begin
			res_status = STAT_MISS;
		end
	end

	assign st.probe_end  = !rd_valid || hit || (n_q == CNTW'(TABLE_SIZE));
	assign st.hash_done  = hash_done;
	assign st.clear_last = (clr_q == IDXW'(TABLE_SIZE - 1));

	// Entry count
	assign occ_nx = store ? count_q + CNTW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.finish) begin
			count_q <= occ_nx;
		end
	end

	// Result register, wide values reported modulo field width
	assign slot_w   = 16'(res_slot);
	assign probes_w = 16'(n_q);
	assign occ_w    = 16'(occ_nx);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status    <= res_status;
			slot      <= slot_w[SLOT_W-1:0];
			probes    <= probes_w[PROBES_W-1:0];
			occupancy <= occ_w[OCC_W-1:0];
		end
	end

	// Walk never steps past the last probe
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (n_q < CNTW'(TABLE_SIZE)))
		else $error("probe walk exceeded table size");

	// Entry count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(TABLE_SIZE))
		else $error("entry count exceeds table size");

	// A committed insert bumps the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && store) |=> (count_q == $past(count_q) + CNTW'(1)))
		else $error("entry count not incremented on insert");

endmodule

// File: rtl/linear_probe_hash_table_top.sv
// Open-addressing hash table of 31-bit keys with linear probing. A request
// (op, key) inserts the key at the first empty slot from its home slot
// (key mod TABLE_SIZE) or searches for it; each request gives one result
// with status, slot, probe count and occupancy. After reset the block runs a
// clearing pass over all TABLE_SIZE slots with in_ready low. The block works
// on one request at a time: it accepts the request, reduces the key to its
// home slot (a registered reciprocal reduction when TABLE_SIZE is not a
// power of two, else the low key bits), reads the home slot and walks on
// slot by slot. The walk is paced by the single read port of the key store.
// A result waiting in the output register does not hold off the next
// request, but the walk of that request holds its last slot until the
// waiting result is taken.
// ---------------------------------------------------------------------------
// linear_probe_hash_table_top: linear probe hash table
// Controller and datapath joined by command and status bundles.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_top #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lpht_pkg::op_t                 op,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lpht_pkg::status_t             status,
	output logic [lpht_pkg::SLOT_W-1:0]   slot,
	output logic [lpht_pkg::PROBES_W-1:0] probes,
	output logic [lpht_pkg::OCC_W-1:0]    occupancy
);

	import lpht_pkg::*;

	cmd_t     cmd;
	dp_stat_t st;

	// Sequencer
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath
	lpht_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (op),
		.in_key    (key),
		.status    (status),
		.slot      (slot),
		.probes    (probes),
		.occupancy (occupancy)
	);

endmodule
